// ----- hw/rtl/gda_pkg.sv -----
// ----------------------------------------------------------------------------
// gda_pkg
// Types, constants and helpers for the Gregorian date arithmetic block.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

  localparam int MAX_YEAR   = 9999;
  localparam int COUNT_BITS = 20;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int CNTP_W  = 20;
  localparam int DIFF_W  = 23;
  localparam int ORDER_W = 2;
  localparam int OP_W    = 2;

  localparam int CNT_W = (COUNT_BITS < CNTP_W) ? COUNT_BITS : CNTP_W;

  localparam int DIFF_LIMIT = 4194303;
  localparam int DAYS_400   = 146097;
  localparam int DAYS_100   = 36524;
  localparam int DAYS_4     = 1461;
  localparam int DAYS_1     = 365;

  // serial of MAX_YEAR-12-31, day 0 is 0001-01-01
  localparam int TOP_SERIAL = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                              + MAX_YEAR / 400 - 1;
  localparam int SER_W = $clog2(TOP_SERIAL + (2 ** CNT_W) + 1) + 1;

  typedef logic [SER_W-1:0]   ser_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIFF = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  localparam logic [ORDER_W-1:0] ORD_EQ      = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_EARLIER = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_LATER   = 2'd2;

  typedef enum logic [1:0] {
    PH_400 = 2'd0,
    PH_100 = 2'd1,
    PH_4   = 2'd2,
    PH_1   = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SER_LD,
    S_YLOOP,
    S_MLOOP,
    S_DAY,
    S_AFTER,
    S_OFFSET,
    S_CHECK,
    S_DIFF_SUB,
    S_DIFF_OUT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    DP_HOLD,
    DP_LOAD,
    DP_STEP,
    DP_ADD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    ser_t   rem_ld;
    ser_t   acc_ld;
    ser_t   k;
    ser_t   inc;
  } dp_ctl_t;

  localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    len = (m > month_t'(12)) ? 5'd0 : MONTH_LEN[m];
    if (m == month_t'(2) && leap) begin
      len = 5'd29;
    end
    return len;
  endfunction

  // year-group sizes in years
  function automatic ser_t years_of(input phase_e ph);
    ser_t v;
    unique case (ph)
      PH_400:  v = ser_t'(400);
      PH_100:  v = ser_t'(100);
      PH_4:    v = ser_t'(4);
      default: v = ser_t'(1);
    endcase
    return v;
  endfunction

  // year-group sizes in days
  function automatic ser_t days_of(input phase_e ph);
    ser_t v;
    unique case (ph)
      PH_400:  v = ser_t'(DAYS_400);
      PH_100:  v = ser_t'(DAYS_100);
      PH_4:    v = ser_t'(DAYS_4);
      default: v = ser_t'(DAYS_1);
    endcase
    return v;
  endfunction

  function automatic year_t clamp_year(input year_t y);
    year_t r;
    r = y;
    if (y == year_t'(0)) begin
      r = year_t'(1);
    end else if (32'(y) > 32'(MAX_YEAR)) begin
      r = year_t'(MAX_YEAR);
    end
    return r;
  endfunction

  function automatic month_t clamp_month(input month_t m);
    month_t r;
    r = m;
    if (m == month_t'(0)) begin
      r = month_t'(1);
    end else if (m > month_t'(12)) begin
      r = month_t'(12);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gda_datapath.sv -----
// ----------------------------------------------------------------------------
// gda_datapath
// Remainder and accumulator registers around one shared compare-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_datapath (
  input  wire              clk_i,
  input  wire gda_pkg::dp_ctl_t ctl_i,
  output gda_pkg::ser_t    rem_o,
  output gda_pkg::ser_t    acc_o,
  output logic             ge_o
);

  gda_pkg::ser_t rem_q, rem_d;
  gda_pkg::ser_t acc_q, acc_d;
  gda_pkg::ser_t sub;
  logic          borrow;

  assign {borrow, sub} = {1'b0, rem_q} - {1'b0, ctl_i.k};
  assign ge_o = ~borrow;

  always_comb begin
    rem_d = rem_q;
    acc_d = acc_q;
    unique case (ctl_i.op)
      gda_pkg::DP_LOAD: begin
        rem_d = ctl_i.rem_ld;
        acc_d = ctl_i.acc_ld;
      end
      gda_pkg::DP_STEP: begin
        rem_d = sub;
        acc_d = acc_q + ctl_i.inc;
      end
      gda_pkg::DP_ADD: begin
        acc_d = acc_q + ctl_i.inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign rem_o = rem_q;
  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- hw/rtl/gregorian_date_arithmetic.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// Adds or subtracts days on a Gregorian date, or gives the day difference
// and order of two dates, through serial day numbers.
// ----------------------------------------------------------------------------
//  channel | signals                 | payload
//  --------+-------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o | operation, date, day_count, date 2
//  out     | out_valid_o/out_ready_i | result date, difference, order, err
//
//  One request at a time; in_ready_o is high only while idle.
//  Each date conversion steps one year group or month per cycle through the
//  shared compare-subtract; from a date, the year groups are those of year - 1.
//  Add/subtract: date to serial, offset, range check, then serial to date;
//  difference: two conversions, then a subtract and a clamp to DIFF_LIMIT.
//  A new request is taken while a result still waits; the block stalls only
//  on a second finished result.
//  Asynchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_arithmetic (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  [gda_pkg::OP_W-1:0]            operation_i,
  input  wire  [gda_pkg::YEAR_W-1:0]          year_i,
  input  wire  [gda_pkg::MONTH_W-1:0]         month_i,
  input  wire  [gda_pkg::DAY_W-1:0]           day_i,
  input  wire  [gda_pkg::CNTP_W-1:0]          day_count_i,
  input  wire  [gda_pkg::YEAR_W-1:0]          other_year_i,
  input  wire  [gda_pkg::MONTH_W-1:0]         other_month_i,
  input  wire  [gda_pkg::DAY_W-1:0]           other_day_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [gda_pkg::YEAR_W-1:0]          result_year_o,
  output logic [gda_pkg::MONTH_W-1:0]         result_month_o,
  output logic [gda_pkg::DAY_W-1:0]           result_day_o,
  output logic signed [gda_pkg::DIFF_W-1:0]   day_difference_o,
  output logic [gda_pkg::ORDER_W-1:0]         order_o,
  output logic                                range_error_o
);

  gda_pkg::state_e state_q, state_d;
  gda_pkg::dp_ctl_t ctl;
  gda_pkg::ser_t    rem, acc;
  logic             ge;

  gda_pkg::op_e     op_q;
  gda_pkg::year_t   y_q, oy_q;
  gda_pkg::month_t  m_q, om_q;
  gda_pkg::day_t    d_q, od_q;
  logic [gda_pkg::CNT_W-1:0] cnt_q;
  logic             second_q;
  logic             dir_to_q;
  gda_pkg::phase_e  ph_q;
  logic [4:0]       qc_q;
  logic             f100_q, f24_q, leap_q;
  gda_pkg::month_t  mo_q;
  gda_pkg::ser_t    s1_q;

  gda_pkg::year_t   res_y_q;
  gda_pkg::month_t  res_m_q;
  gda_pkg::day_t    res_d_q;
  gda_pkg::diff_t   res_diff_q;
  logic [gda_pkg::ORDER_W-1:0] res_ord_q;
  logic             res_err_q;

  logic             out_valid_q;

  gda_pkg::year_t   cur_y;
  gda_pkg::month_t  cur_m;
  gda_pkg::day_t    cur_d;
  gda_pkg::day_t    mlen;
  gda_pkg::day_t    dcl;
  logic             capped;
  logic             step_ok;
  logic             out_free;
  int               dv;

  assign cur_y = second_q ? oy_q : y_q;
  assign cur_m = second_q ? om_q : m_q;
  assign cur_d = second_q ? od_q : d_q;
  assign mlen  = gda_pkg::month_len(mo_q, leap_q);

  always_comb begin
    gda_pkg::day_t len;
    len = gda_pkg::month_len(cur_m, leap_q);
    dcl = cur_d;
    if (cur_d == '0) begin
      dcl = gda_pkg::day_t'(1);
    end else if (cur_d > len) begin
      dcl = len;
    end
  end

  assign capped   = (ph_q == gda_pkg::PH_100) || (ph_q == gda_pkg::PH_1);
  assign step_ok  = ge && !(capped && qc_q == 5'd3);
  assign out_free = !out_valid_q || out_ready_i;
  assign dv       = int'($signed(rem));

  gda_datapath u_dp (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .rem_o (rem),
    .acc_o (acc),
    .ge_o  (ge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gda_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl.op     = gda_pkg::DP_HOLD;
    ctl.rem_ld = acc;
    ctl.acc_ld = '0;
    ctl.k      = dir_to_q ? gda_pkg::years_of(ph_q) : gda_pkg::days_of(ph_q);
    ctl.inc    = dir_to_q ? gda_pkg::days_of(ph_q) : gda_pkg::years_of(ph_q);
    in_ready_o = 1'b0;
    unique case (state_q)
      gda_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = gda_pkg::S_SER_LD;
        end
      end
      gda_pkg::S_SER_LD: begin
        ctl.op     = gda_pkg::DP_LOAD;
        ctl.rem_ld = gda_pkg::ser_t'(cur_y) - gda_pkg::ser_t'(1);
        state_d    = gda_pkg::S_YLOOP;
      end
      gda_pkg::S_YLOOP: begin
        if (step_ok) begin
          ctl.op = gda_pkg::DP_STEP;
        end else if (ph_q == gda_pkg::PH_1) begin
          state_d = gda_pkg::S_MLOOP;
        end
      end
      gda_pkg::S_MLOOP: begin
        ctl.k   = gda_pkg::ser_t'(mlen);
        ctl.inc = dir_to_q ? gda_pkg::ser_t'(mlen) : '0;
        if (dir_to_q) begin
          if (mo_q < cur_m) begin
            ctl.op = gda_pkg::DP_ADD;
          end else begin
            state_d = gda_pkg::S_DAY;
          end
        end else if (mo_q < gda_pkg::month_t'(12) && ge) begin
          ctl.op = gda_pkg::DP_STEP;
        end else begin
          state_d = gda_pkg::S_DONE;
        end
      end
      gda_pkg::S_DAY: begin
        ctl.op  = gda_pkg::DP_ADD;
        ctl.inc = gda_pkg::ser_t'(dcl - gda_pkg::day_t'(1));
        state_d = gda_pkg::S_AFTER;
      end
      gda_pkg::S_AFTER: begin
        if (second_q) begin
          ctl.op     = gda_pkg::DP_LOAD;
          ctl.rem_ld = s1_q;
          ctl.acc_ld = acc;
          state_d    = gda_pkg::S_DIFF_SUB;
        end else begin
          case (op_q) inside
            gda_pkg::OP_ADD, gda_pkg::OP_SUB: state_d = gda_pkg::S_OFFSET;
            gda_pkg::OP_DIFF:                 state_d = gda_pkg::S_SER_LD;
            default:                          state_d = gda_pkg::S_DONE;
          endcase
        end
      end
      gda_pkg::S_OFFSET: begin
        ctl.op  = gda_pkg::DP_ADD;
        ctl.inc = (op_q == gda_pkg::OP_ADD) ? gda_pkg::ser_t'(cnt_q)
                                            : -gda_pkg::ser_t'(cnt_q);
        state_d = gda_pkg::S_CHECK;
      end
      gda_pkg::S_CHECK: begin
        if (acc[gda_pkg::SER_W-1] ||
            $signed(acc) > $signed(gda_pkg::ser_t'(gda_pkg::TOP_SERIAL))) begin
          state_d = gda_pkg::S_DONE;
        end else begin
          ctl.op     = gda_pkg::DP_LOAD;
          ctl.rem_ld = acc;
          state_d    = gda_pkg::S_YLOOP;
        end
      end
      gda_pkg::S_DIFF_SUB: begin
        ctl.op  = gda_pkg::DP_STEP;
        ctl.k   = acc;
        ctl.inc = '0;
        state_d = gda_pkg::S_DIFF_OUT;
      end
      gda_pkg::S_DIFF_OUT: begin
        state_d = gda_pkg::S_DONE;
      end
      gda_pkg::S_DONE: begin
        if (out_free) begin
          state_d = gda_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gda_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gda_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_q       <= gda_pkg::op_e'(operation_i);
          y_q        <= gda_pkg::clamp_year(year_i);
          m_q        <= gda_pkg::clamp_month(month_i);
          d_q        <= day_i;
          oy_q       <= gda_pkg::clamp_year(other_year_i);
          om_q       <= gda_pkg::clamp_month(other_month_i);
          od_q       <= other_day_i;
          cnt_q      <= day_count_i[gda_pkg::CNT_W-1:0];
          second_q   <= 1'b0;
          res_diff_q <= '0;
          res_ord_q  <= gda_pkg::ORD_EQ;
          res_err_q  <= 1'b0;
        end
      end
      gda_pkg::S_SER_LD: begin
        dir_to_q <= 1'b1;
        ph_q     <= gda_pkg::PH_400;
        qc_q     <= '0;
      end
      gda_pkg::S_YLOOP: begin
        if (step_ok) begin
          if (ph_q != gda_pkg::PH_400) begin
            qc_q <= qc_q + 5'd1;
          end
        end else begin
          qc_q <= '0;
          if (ph_q == gda_pkg::PH_100) begin
            f100_q <= (qc_q == 5'd3);
          end
          if (ph_q == gda_pkg::PH_4) begin
            f24_q <= (qc_q == 5'd24);
          end
          if (ph_q == gda_pkg::PH_1) begin
            leap_q <= (qc_q == 5'd3) && !(f24_q && !f100_q);
            mo_q   <= gda_pkg::month_t'(1);
          end else begin
            ph_q <= gda_pkg::phase_e'(ph_q + 2'd1);
          end
        end
      end
      gda_pkg::S_MLOOP: begin
        if (dir_to_q) begin
          if (mo_q < cur_m) begin
            mo_q <= mo_q + gda_pkg::month_t'(1);
          end
        end else if (mo_q < gda_pkg::month_t'(12) && ge) begin
          mo_q <= mo_q + gda_pkg::month_t'(1);
        end else begin
          res_y_q <= gda_pkg::year_t'(acc + gda_pkg::ser_t'(1));
          res_m_q <= mo_q;
          res_d_q <= gda_pkg::day_t'(rem) + gda_pkg::day_t'(1);
        end
      end
      gda_pkg::S_DAY: begin
        if (second_q) begin
          od_q <= dcl;
        end else begin
          d_q <= dcl;
        end
      end
      gda_pkg::S_AFTER: begin
        if (!second_q) begin
          s1_q    <= acc;
          res_y_q <= y_q;
          res_m_q <= m_q;
          res_d_q <= d_q;
          if (op_q == gda_pkg::OP_DIFF) begin
            second_q <= 1'b1;
          end
        end
      end
      gda_pkg::S_CHECK: begin
        if (acc[gda_pkg::SER_W-1]) begin
          res_err_q <= 1'b1;
          res_y_q   <= gda_pkg::year_t'(1);
          res_m_q   <= gda_pkg::month_t'(1);
          res_d_q   <= gda_pkg::day_t'(1);
        end else if ($signed(acc) >
                     $signed(gda_pkg::ser_t'(gda_pkg::TOP_SERIAL))) begin
          res_err_q <= 1'b1;
          res_y_q   <= gda_pkg::year_t'(gda_pkg::MAX_YEAR);
          res_m_q   <= gda_pkg::month_t'(12);
          res_d_q   <= gda_pkg::day_t'(31);
        end else begin
          dir_to_q <= 1'b0;
          ph_q     <= gda_pkg::PH_400;
          qc_q     <= '0;
        end
      end
      gda_pkg::S_DIFF_OUT: begin
        if (dv > gda_pkg::DIFF_LIMIT) begin
          res_diff_q <= gda_pkg::diff_t'(gda_pkg::DIFF_LIMIT);
        end else if (dv < -gda_pkg::DIFF_LIMIT) begin
          res_diff_q <= gda_pkg::diff_t'(-gda_pkg::DIFF_LIMIT);
        end else begin
          res_diff_q <= gda_pkg::diff_t'(dv);
        end
        if (dv == 0) begin
          res_ord_q <= gda_pkg::ORD_EQ;
        end else if (dv < 0) begin
          res_ord_q <= gda_pkg::ORD_EARLIER;
        end else begin
          res_ord_q <= gda_pkg::ORD_LATER;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == gda_pkg::S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == gda_pkg::S_DONE && out_free) begin
      result_year_o    <= res_y_q;
      result_month_o   <= res_m_q;
      result_day_o     <= res_d_q;
      day_difference_o <= res_diff_q;
      order_o          <= res_ord_q;
      range_error_o    <= res_err_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted a request while busy");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gda_pkg::S_MLOOP) |-> (mo_q >= 4'd1 && mo_q <= 4'd12))
    else $error("month counter out of range");

  a_group_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gda_pkg::S_YLOOP) |-> (qc_q <= 5'd24))
    else $error("year group count overflow");

  a_sat_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |->
      ((result_year_o == 14'd1 && result_month_o == 4'd1 && result_day_o == 5'd1) ||
       (result_month_o == 4'd12 && result_day_o == 5'd31)))
    else $error("range error without saturated date");
`endif

endmodule

`default_nettype wire
